>>> src/bbrs_pkg.sv
// Shared types and constants for the block byte reorder bit serializer.
package bbrs_pkg;

    localparam int unsigned CFG_DATA_W  = 24;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned FILL_W      = 3;
    localparam int unsigned SIZE_W      = 4;
    localparam int unsigned ORDER_IDX_W = 3;
    localparam int unsigned ORDER_N     = 8;
    localparam int unsigned BYTE_BITS   = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_COUNT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ORDER_LIST = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LSB_FIRST  = 3'd3;

    localparam logic [SIZE_W-1:0]     RST_BLOCK_SIZE = 4'd4;
    localparam logic [SIZE_W-1:0]     RST_OUT_COUNT  = 4'd4;
    localparam logic [CFG_DATA_W-1:0] RST_ORDER_LIST = 24'd1672;
    localparam logic                  RST_LSB_FIRST  = 1'b0;

    localparam logic [SIZE_W-1:0] MAX_OUT_COUNT = 4'd8;

    typedef struct packed {
        logic [SIZE_W-1:0]                       out_count;
        logic [ORDER_N-1:0][ORDER_IDX_W-1:0]     order_list;
        logic                                    lsb_first;
    } back_cfg_t;

endpackage

>>> src/bbrs_front.sv
// Front end: gathers request bytes into the block store and pushes full blocks.
module bbrs_front #(
    parameter int unsigned MAX_BLOCK = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           data_byte,
    input  logic [bbrs_pkg::SIZE_W-1:0]          block_size,
    input  logic                                 q_full,
    output logic                                 q_push,
    output logic [MAX_BLOCK-1:0][7:0]            q_block
);
    import bbrs_pkg::*;

    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_BLOCK);

    logic [MAX_BLOCK-1:0][7:0] store_reg;
    logic [FILL_W-1:0]         fill_reg;
    logic [FILL_W-1:0]         fill_next;
    logic [SIZE_W-1:0]         size_eff;
    logic                      complete;
    logic                      accept;

    always_comb
    begin
        if (block_size == '0)
            size_eff = SIZE_W'(1);
        else if (block_size > MAX_SIZE)
            size_eff = MAX_SIZE;
        else
            size_eff = block_size;
    end

    assign complete  = ({1'b0, fill_reg} + SIZE_W'(1)) >= size_eff;
    assign in_stall  = complete & q_full;
    assign accept    = in_valid & ~in_stall;
    assign q_push    = accept & complete;
    assign fill_next = complete ? '0 : fill_reg + FILL_W'(1);

    always_comb
    begin
        for (int i = 0; i < MAX_BLOCK; i++)
        begin
            q_block[i] = (fill_reg == FILL_W'(i)) ? data_byte : store_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (accept)
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_BLOCK; i++)
        begin
            if (accept && fill_reg == FILL_W'(i))
                store_reg[i] <= data_byte;
        end
    end

endmodule

>>> src/bbrs_queue.sv
// Two-entry block queue between the front end and the serializer.
module bbrs_queue #(
    parameter int unsigned MAX_BLOCK = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [MAX_BLOCK-1:0][7:0]  push_block,
    output logic                       full,
    input  logic                       pop,
    output logic                       not_empty,
    output logic [MAX_BLOCK-1:0][7:0]  head_block
);
    import bbrs_pkg::*;

    logic [MAX_BLOCK-1:0][7:0] mem_reg [2];
    logic                      wr_ptr_reg;
    logic                      rd_ptr_reg;
    logic [1:0]                count_reg;
    logic [1:0]                count_next;
    logic                      do_push;
    logic                      do_pop;

    assign full       = (count_reg == 2'd2);
    assign not_empty  = (count_reg != 2'd0);
    assign do_push    = push & ~full;
    assign do_pop     = pop & not_empty;
    assign head_block = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_block;
    end

endmodule

>>> src/bbrs_back.sv
// Back end: walks the order list of one block and emits its bits one per cycle while out_stall does not hold them.
module bbrs_back #(
    parameter int unsigned MAX_BLOCK = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bbrs_pkg::back_cfg_t        cfg,
    input  logic                       q_not_empty,
    input  logic [MAX_BLOCK-1:0][7:0]  q_head,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       bit_value,
    output logic                       last_bit
);
    import bbrs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [MAX_BLOCK-1:0][7:0] blk_reg;
    logic [SIZE_W-1:0]         cnt_reg;
    logic [SIZE_W-1:0]         cnt_load;
    logic [ORDER_IDX_W-1:0]    k_reg;
    logic [2:0]                j_reg;
    logic                      valid_reg;
    logic                      bit_reg;
    logic                      last_reg;
    logic                      room;
    logic                      emit;
    logic [ORDER_IDX_W-1:0]    idx;
    logic [7:0]                sel_byte;
    logic [2:0]                sh;
    logic                      cur_last;

    assign cnt_load = (cfg.out_count > MAX_OUT_COUNT) ? MAX_OUT_COUNT : cfg.out_count;
    assign q_pop    = (state_reg == S_IDLE) & q_not_empty;
    assign room     = ~valid_reg | ~out_stall;
    assign emit     = (state_reg == S_RUN) & room;
    assign idx      = cfg.order_list[k_reg];
    assign sh       = cfg.lsb_first ? j_reg : 3'd7 - j_reg;
    assign cur_last = (({1'b0, k_reg} + SIZE_W'(1)) == cnt_reg) && (j_reg == 3'd7);

    always_comb
    begin
        sel_byte = '0;
        for (int i = 0; i < MAX_BLOCK; i++)
        begin
            if (idx == ORDER_IDX_W'(i))
                sel_byte = blk_reg[i];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty && cnt_load != '0)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (emit && cur_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            k_reg     <= '0;
            j_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                cnt_reg <= cnt_load;
                k_reg   <= '0;
                j_reg   <= '0;
            end
            if (emit)
            begin
                valid_reg <= 1'b1;
                j_reg     <= j_reg + 3'd1;
                if (j_reg == 3'd7)
                    k_reg <= k_reg + ORDER_IDX_W'(1);
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            blk_reg <= q_head;
        if (emit)
        begin
            bit_reg  <= sel_byte[sh];
            last_reg <= cur_last;
        end
    end

    assign out_valid = valid_reg;
    assign bit_value = bit_reg;
    assign last_bit  = last_reg;

endmodule

>>> src/block_byte_reorder_bit_serializer.sv
// Top level of the block byte reorder bit serializer.
//
// Input channel: one byte per request on data_byte, handshake in_valid/in_stall.
// Bytes gather into a block of block_size bytes. The byte that completes a
// block pushes the whole block into a two-entry queue; a partial block never
// emits. Output channel: one bit per request on bit_value with last_bit on the
// final bit of a block, handshake out_valid/out_stall.
// For each block, out_count bytes are taken in order_list order, each sent as
// eight bits, MSB first or LSB first per lsb_first. The serializer emits one
// bit per cycle unless out_stall holds it, and loads each block in its idle
// state first; a completing byte reaches bit_value through the queue, the
// block register and the bit register. Bytes are taken one per cycle until
// the queue holds two blocks; in_stall then rises on the next completing byte.
// A stalled output holds its bit and the serializer waits. Reset clears the
// fill count, the queue and out_valid, and loads the register defaults; the
// block store itself is not cleared. Registers are written by the user through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module block_byte_reorder_bit_serializer #(
    parameter int unsigned MAX_BLOCK = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bbrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bbrs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          data_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                bit_value,
    output logic                                last_bit
);
    import bbrs_pkg::*;

    logic [SIZE_W-1:0]         block_size_reg;
    logic [SIZE_W-1:0]         out_count_reg;
    logic [CFG_DATA_W-1:0]     order_list_reg;
    logic                      lsb_first_reg;
    back_cfg_t                 back_cfg;
    logic                      q_push;
    logic                      q_full;
    logic                      q_pop;
    logic                      q_not_empty;
    logic [MAX_BLOCK-1:0][7:0] push_block;
    logic [MAX_BLOCK-1:0][7:0] head_block;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= RST_BLOCK_SIZE;
            out_count_reg  <= RST_OUT_COUNT;
            order_list_reg <= RST_ORDER_LIST;
            lsb_first_reg  <= RST_LSB_FIRST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BLOCK_SIZE: block_size_reg <= cfg_data[SIZE_W-1:0];
                REG_OUT_COUNT:  out_count_reg  <= cfg_data[SIZE_W-1:0];
                REG_ORDER_LIST: order_list_reg <= cfg_data;
                REG_LSB_FIRST:  lsb_first_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        back_cfg.out_count  = out_count_reg;
        back_cfg.order_list = order_list_reg;
        back_cfg.lsb_first  = lsb_first_reg;
    end

    bbrs_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .block_size (block_size_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_block    (push_block)
    );

    bbrs_queue #(.MAX_BLOCK(MAX_BLOCK)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_block (push_block),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head_block (head_block)
    );

    bbrs_back #(.MAX_BLOCK(MAX_BLOCK)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (back_cfg),
        .q_not_empty (q_not_empty),
        .q_head      (head_block),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bit_value   (bit_value),
        .last_bit    (last_bit)
    );

endmodule
